@@ rtl/szs_pkg.sv @@
// ----------------------------------------------------------------------------
// szs_pkg
// Shared codes, field widths and types of the 7z streams-info header parser.
// ----------------------------------------------------------------------------
package szs_pkg;

   // parse phase codes
   localparam logic [5:0] PH_FIRST       = 6'd0;
   localparam logic [5:0] PH_PACK_ID     = 6'd1;
   localparam logic [5:0] PH_PACK_POS    = 6'd2;
   localparam logic [5:0] PH_NUM_PACK    = 6'd3;
   localparam logic [5:0] PH_PACK_PROP   = 6'd4;
   localparam logic [5:0] PH_PACK_SIZE   = 6'd5;
   localparam logic [5:0] PH_SKIP_LEN    = 6'd6;
   localparam logic [5:0] PH_SKIPPING    = 6'd7;
   localparam logic [5:0] PH_UNPACK_ID   = 6'd8;
   localparam logic [5:0] PH_UNPACK_PROP = 6'd9;
   localparam logic [5:0] PH_NUM_FOLDERS = 6'd10;
   localparam logic [5:0] PH_EXTERNAL    = 6'd11;
   localparam logic [5:0] PH_NUM_CODERS  = 6'd12;
   localparam logic [5:0] PH_CODER_MAIN  = 6'd13;
   localparam logic [5:0] PH_CODER_IN    = 6'd14;
   localparam logic [5:0] PH_CODER_OUT   = 6'd15;
   localparam logic [5:0] PH_PROPS_SIZE  = 6'd16;
   localparam logic [5:0] PH_BOND_IN     = 6'd17;
   localparam logic [5:0] PH_BOND_OUT    = 6'd18;
   localparam logic [5:0] PH_PACK_INDEX  = 6'd19;
   localparam logic [5:0] PH_CODER_SIZE  = 6'd20;
   localparam logic [5:0] PH_DIGEST_ALL  = 6'd21;
   localparam logic [5:0] PH_DIGEST_BITS = 6'd22;
   localparam logic [5:0] PH_CRC         = 6'd23;
   localparam logic [5:0] PH_DONE        = 6'd24;
   // return actions after a skip
   localparam logic [5:0] ACT_AFTER_ID   = 6'd40;
   localparam logic [5:0] ACT_CODER_NEXT = 6'd41;

   // section flag bit positions
   localparam int SF_PACK_SIZES  = 0;
   localparam int SF_FOLDER      = 1;
   localparam int SF_CODER_SIZES = 2;
   localparam int SF_CRC         = 3;

   // property ids
   localparam logic [63:0] ID_PACK_INFO   = 64'h06;
   localparam logic [63:0] ID_UNPACK_INFO = 64'h07;
   localparam logic [63:0] ID_SIZE        = 64'h09;
   localparam logic [63:0] ID_CRC         = 64'h0A;
   localparam logic [63:0] ID_FOLDER      = 64'h0B;
   localparam logic [63:0] ID_CODER_SIZE  = 64'h0C;
   localparam logic [63:0] ID_END         = 64'h00;

   localparam logic [63:0] LIMIT32 = 64'h7FFF_FFFF;

   // result kinds
   localparam logic [1:0] KIND_SUMMARY = 2'd0;
   localparam logic [1:0] KIND_PACK_POS = 2'd1;
   localparam logic [1:0] KIND_PACK_SIZE = 2'd2;
   localparam logic [1:0] KIND_CODER_SIZE = 2'd3;

   // record snapshot handed from parser to emitter
   typedef struct packed {
      logic        ok;
      logic [63:0] pack_position;
      logic [5:0]  pack_num;
      logic [3:0]  coder_num;
      logic [2:0]  main_coder;
      logic [15:0] folder_start;
      logic [15:0] folder_length;
      logic [31:0] folder_crc;
      logic        crc_present;
   } summary_type;

endpackage

@@ rtl/szs_byte_queue.sv @@
// ----------------------------------------------------------------------------
// szs_byte_queue
// Two-entry queue of record bytes between the input port and the parser.
// ----------------------------------------------------------------------------
module szs_byte_queue import szs_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  logic [7:0] in_byte,
   input  logic       in_last,
   output logic       out_valid,
   input  logic       out_ready,
   output logic [7:0] out_byte,
   output logic       out_last
);

   logic [7:0] data_ff [2];
   logic       last_ff [2];
   logic       wptr_ff, wptr_in;
   logic       rptr_ff, rptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   // handshake on both sides
   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_byte  = data_ff[rptr_ff];
   assign out_last  = last_ff[rptr_ff];

   // pointer and fill update
   always_comb begin
      wptr_in  = push ? ~wptr_ff : wptr_ff;
      rptr_in  = pop ? ~rptr_ff : rptr_ff;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         data_ff[wptr_ff] <= in_byte;
         last_ff[wptr_ff] <= in_last;
      end
   end

endmodule

@@ rtl/szs_parser.sv @@
// ----------------------------------------------------------------------------
// szs_parser
// Byte-at-a-time parser of PackInfo and UnpackInfo, one byte per cycle while the emitter is idle.
// ----------------------------------------------------------------------------
module szs_parser import szs_pkg::*; #(
   parameter int MAX_STREAMS      = 8,
   parameter int MAX_CODERS       = 4,
   parameter int RECORD_BYTES_MAX = 65536,
   localparam int SIW = (MAX_STREAMS > 1) ? $clog2(MAX_STREAMS) : 1,
   localparam int CIW = (MAX_CODERS > 1) ? $clog2(MAX_CODERS) : 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [7:0]        in_byte,
   input  logic              in_last,
   input  logic              emit_busy,
   output logic              start,
   output summary_type       summary,
   input  logic [SIW-1:0]    pack_rd_idx,
   output logic [63:0]       pack_rd_data,
   input  logic [CIW-1:0]    coder_rd_idx,
   output logic [63:0]       coder_rd_data
);

   localparam int SCW  = $clog2(MAX_STREAMS + 1);
   localparam int CCW  = $clog2(MAX_CODERS + 1);
   localparam int LM1  = (MAX_STREAMS > MAX_CODERS) ? MAX_STREAMS : MAX_CODERS;
   localparam int LM2  = (LM1 > 4) ? LM1 : 4;
   localparam int LW   = $clog2(LM2 + 1);
   localparam int OW   = $clog2(RECORD_BYTES_MAX + 2);
   localparam int SUW  = 2 ** SIW;
   localparam int CUW  = 2 ** CIW;

   logic [5:0]     phase_ff, phase_in;
   logic [63:0]    acc_ff, acc_in;
   logic [7:0]     lead_ff, lead_in;
   logic [3:0]     cnt_ff, cnt_in;
   logic [3:0]     need_ff, need_in;
   logic           active_ff, active_in;
   logic [63:0]    skip_ff, skip_in;
   logic [5:0]     ret_ff, ret_in;
   logic [OW-1:0]  offset_ff, offset_in;
   logic [63:0]    ppos_ff, ppos_in;
   logic [63:0]    ptotal_ff, ptotal_in;
   logic [LW-1:0]  loop_ff, loop_in;
   logic [7:0]     flags_ff, flags_in;
   logic [SCW-1:0] stotal_ff, stotal_in;
   logic [30:0]    inputs_ff, inputs_in;
   logic [SCW-1:0] pcount_ff, pcount_in;
   logic [CCW-1:0] ccount_ff, ccount_in;
   logic [CIW-1:0] main_ff, main_in;
   logic [CUW-1:0] cused_ff, cused_in;
   logic [SUW-1:0] sused_ff, sused_in;
   logic [3:0]     sect_ff, sect_in;
   logic [31:0]    crc_ff, crc_in;
   logic           rej_ff, rej_in;
   logic [15:0]    fstart_ff, fstart_in;
   logic [15:0]    flen_ff, flen_in;

   logic [63:0]    pack_sizes_ff  [MAX_STREAMS];
   logic [63:0]    coder_sizes_ff [MAX_CODERS];

   logic           take;
   logic           ps_we, cs_we;
   logic [SIW-1:0] ps_idx;
   logic [CIW-1:0] cs_idx;
   logic [63:0]    wr_data;

   assign in_ready      = !emit_busy;
   assign take          = in_valid && in_ready;
   assign start         = take && in_last;
   assign pack_rd_data  = pack_sizes_ff[pack_rd_idx];
   assign coder_rd_data = coder_sizes_ff[coder_rd_idx];

   // next state of the parse for the byte taken this cycle
   always_comb begin
      logic        is_num, done, run, skip_req, do_enter, do_add, do_next;
      logic        do_pis, do_ff, found;
      logic [3:0]  nlead;
      logic [63:0] v, skip_n;
      logic [5:0]  skip_r, ecode;
      logic [64:0] t;
      logic [CCW-1:0] bonds;

      phase_in = phase_ff; acc_in = acc_ff; lead_in = lead_ff; cnt_in = cnt_ff;
      need_in = need_ff; active_in = active_ff; skip_in = skip_ff; ret_in = ret_ff;
      offset_in = offset_ff; ppos_in = ppos_ff; ptotal_in = ptotal_ff;
      loop_in = loop_ff; flags_in = flags_ff; stotal_in = stotal_ff;
      inputs_in = inputs_ff; pcount_in = pcount_ff; ccount_in = ccount_ff;
      main_in = main_ff; cused_in = cused_ff; sused_in = sused_ff; sect_in = sect_ff;
      crc_in = crc_ff; rej_in = rej_ff; fstart_in = fstart_ff; flen_in = flen_ff;
      ps_we = 1'b0; cs_we = 1'b0; ps_idx = loop_ff[SIW-1:0]; cs_idx = loop_ff[CIW-1:0];
      is_num = 1'b0; done = 1'b0; run = 1'b1; nlead = 4'd0; v = 64'd0;
      skip_req = 1'b0; skip_n = 64'd0; skip_r = PH_FIRST; do_enter = 1'b0;
      ecode = PH_FIRST; do_add = 1'b0; do_next = 1'b0; do_pis = 1'b0; do_ff = 1'b0;
      found = 1'b0; t = 65'd0; bonds = '0;
      wr_data = acc_in;

      if (take && !rej_ff) begin
         if (offset_ff >= OW'(RECORD_BYTES_MAX)) begin
            rej_in = 1'b1;
         end else begin
            // byte-level phases
            case (phase_ff)
               PH_FIRST: phase_in = PH_PACK_ID;
               PH_SKIPPING: begin
                  skip_in = skip_ff - 64'd1;
                  if (skip_in == 64'd0) begin
                     do_enter = 1'b1;
                     ecode    = ret_ff;
                  end
               end
               PH_EXTERNAL: begin
                  if (in_byte != 8'd0) begin
                     rej_in = 1'b1;
                  end else begin
                     fstart_in = 16'(offset_ff) + 16'd1;
                     phase_in  = PH_NUM_CODERS;
                  end
               end
               PH_CODER_MAIN: begin
                  if ((in_byte & 8'hC0) != 8'd0 || in_byte[3:0] > 4'd8) begin
                     rej_in = 1'b1;
                  end else begin
                     flags_in = in_byte;
                     skip_req = 1'b1;
                     skip_n   = 64'(in_byte[3:0]);
                     skip_r   = ACT_AFTER_ID;
                  end
               end
               PH_DIGEST_ALL: begin
                  if (in_byte != 8'd0) begin
                     crc_in = 32'd0; loop_in = '0; phase_in = PH_CRC;
                  end else begin
                     phase_in = PH_DIGEST_BITS;
                  end
               end
               PH_DIGEST_BITS: begin
                  if (in_byte[7]) begin
                     crc_in = 32'd0; loop_in = '0; phase_in = PH_CRC;
                  end else begin
                     phase_in = PH_UNPACK_PROP;
                  end
               end
               PH_CRC: begin
                  crc_in  = crc_ff | (32'(in_byte) << {loop_ff[1:0], 3'b000});
                  loop_in = loop_ff + LW'(1);
                  if (loop_in >= LW'(4)) begin
                     sect_in[SF_CRC] = 1'b1;
                     phase_in = PH_UNPACK_PROP;
                  end
               end
               PH_DONE: ;
               default: is_num = 1'b1;
            endcase

            // variable-length number decode
            if (is_num) begin
               if (!active_ff) begin
                  for (int i = 0; i < 8; i++) begin
                     if (run && in_byte[7-i]) nlead = nlead + 4'd1;
                     else run = 1'b0;
                  end
                  if (nlead == 4'd0) begin
                     acc_in = 64'(in_byte);
                     done   = 1'b1;
                  end else begin
                     lead_in = in_byte; need_in = nlead; cnt_in = 4'd0;
                     acc_in = 64'd0; active_in = 1'b1;
                  end
               end else begin
                  acc_in = acc_ff | (64'(in_byte) << {cnt_ff[2:0], 3'b000});
                  cnt_in = cnt_ff + 4'd1;
                  if (cnt_in == need_ff) begin
                     if (need_ff < 4'd8)
                        acc_in = acc_in | (64'(lead_ff & (8'hFF >> (need_ff + 4'd1)))
                                           << {need_ff[2:0], 3'b000});
                     active_in = 1'b0;
                     done      = 1'b1;
                  end
               end
               v       = acc_in;
               wr_data = acc_in;
            end

            // act on a complete number
            if (done) begin
               if ((phase_ff == PH_NUM_PACK || phase_ff == PH_NUM_FOLDERS ||
                    phase_ff == PH_NUM_CODERS || phase_ff == PH_CODER_IN ||
                    phase_ff == PH_CODER_OUT || phase_ff == PH_PROPS_SIZE ||
                    phase_ff == PH_BOND_IN || phase_ff == PH_BOND_OUT ||
                    phase_ff == PH_PACK_INDEX) && v >= LIMIT32) begin
                  rej_in = 1'b1;
               end else begin
                  case (phase_ff)
                     PH_PACK_ID: begin
                        if (v != ID_PACK_INFO) rej_in = 1'b1;
                        else phase_in = PH_PACK_POS;
                     end
                     PH_PACK_POS: begin
                        ppos_in  = v;
                        phase_in = PH_NUM_PACK;
                     end
                     PH_NUM_PACK: begin
                        if (v == 64'd0 || v > 64'(MAX_STREAMS)) begin
                           rej_in = 1'b1;
                        end else begin
                           pcount_in = v[SCW-1:0];
                           phase_in  = PH_PACK_PROP;
                        end
                     end
                     PH_PACK_PROP: begin
                        if (v == ID_END) begin
                           if (!sect_ff[SF_PACK_SIZES]) rej_in = 1'b1;
                           else phase_in = PH_UNPACK_ID;
                        end else if (v == ID_SIZE) begin
                           if (sect_ff[SF_PACK_SIZES]) begin
                              rej_in = 1'b1;
                           end else begin
                              loop_in = '0; ptotal_in = 64'd0; phase_in = PH_PACK_SIZE;
                           end
                        end else begin
                           ret_in = PH_PACK_PROP; phase_in = PH_SKIP_LEN;
                        end
                     end
                     PH_PACK_SIZE: begin
                        t = {1'b0, ptotal_ff} + {1'b0, v};
                        if (t[64] || loop_ff >= LW'(MAX_STREAMS)) begin
                           rej_in = 1'b1;
                        end else begin
                           ptotal_in = t[63:0];
                           ps_we     = 1'b1;
                           loop_in   = loop_ff + LW'(1);
                           if (loop_in >= LW'(pcount_ff)) begin
                              sect_in[SF_PACK_SIZES] = 1'b1;
                              phase_in = PH_PACK_PROP;
                           end
                        end
                     end
                     PH_SKIP_LEN: begin
                        skip_req = 1'b1; skip_n = v; skip_r = ret_ff;
                     end
                     PH_UNPACK_ID: begin
                        if (v != ID_UNPACK_INFO) rej_in = 1'b1;
                        else phase_in = PH_UNPACK_PROP;
                     end
                     PH_UNPACK_PROP: begin
                        if (v == ID_END) begin
                           if (!sect_ff[SF_FOLDER] || !sect_ff[SF_CODER_SIZES]) rej_in = 1'b1;
                           else phase_in = PH_DONE;
                        end else if (v == ID_FOLDER) begin
                           if (sect_ff[SF_FOLDER]) rej_in = 1'b1;
                           else phase_in = PH_NUM_FOLDERS;
                        end else if (v == ID_CODER_SIZE) begin
                           if (!sect_ff[SF_FOLDER] || sect_ff[SF_CODER_SIZES]) begin
                              rej_in = 1'b1;
                           end else begin
                              loop_in = '0; phase_in = PH_CODER_SIZE;
                           end
                        end else if (v == ID_CRC) begin
                           if (sect_ff[SF_CRC]) rej_in = 1'b1;
                           else phase_in = PH_DIGEST_ALL;
                        end else begin
                           ret_in = PH_UNPACK_PROP; phase_in = PH_SKIP_LEN;
                        end
                     end
                     PH_NUM_FOLDERS: begin
                        if (v != 64'd1) rej_in = 1'b1;
                        else phase_in = PH_EXTERNAL;
                     end
                     PH_NUM_CODERS: begin
                        if (v == 64'd0 || v > 64'(MAX_CODERS)) begin
                           rej_in = 1'b1;
                        end else begin
                           ccount_in = v[CCW-1:0]; loop_in = '0; stotal_in = '0;
                           phase_in  = PH_CODER_MAIN;
                        end
                     end
                     PH_CODER_IN: begin
                        inputs_in = v[30:0];
                        phase_in  = PH_CODER_OUT;
                     end
                     PH_CODER_OUT: begin
                        if (v != 64'd1) rej_in = 1'b1;
                        else do_add = 1'b1;
                     end
                     PH_PROPS_SIZE: begin
                        skip_req = 1'b1; skip_n = v; skip_r = ACT_CODER_NEXT;
                     end
                     PH_BOND_IN: begin
                        if (v >= 64'(stotal_ff) || sused_ff[v[SIW-1:0]]) begin
                           rej_in = 1'b1;
                        end else begin
                           sused_in[v[SIW-1:0]] = 1'b1;
                           phase_in = PH_BOND_OUT;
                        end
                     end
                     PH_BOND_OUT: begin
                        if (v >= 64'(ccount_ff) || cused_ff[v[CIW-1:0]]) begin
                           rej_in = 1'b1;
                        end else begin
                           cused_in[v[CIW-1:0]] = 1'b1;
                           loop_in = loop_ff + LW'(1);
                           if (loop_in < LW'(ccount_ff) - LW'(1)) phase_in = PH_BOND_IN;
                           else do_pis = 1'b1;
                        end
                     end
                     PH_PACK_INDEX: begin
                        if (v >= 64'(stotal_ff) || sused_ff[v[SIW-1:0]]) begin
                           rej_in = 1'b1;
                        end else begin
                           sused_in[v[SIW-1:0]] = 1'b1;
                           loop_in = loop_ff + LW'(1);
                           if (loop_in >= LW'(pcount_ff)) do_ff = 1'b1;
                        end
                     end
                     PH_CODER_SIZE: begin
                        if (loop_ff >= LW'(MAX_CODERS)) begin
                           rej_in = 1'b1;
                        end else begin
                           cs_we   = 1'b1;
                           loop_in = loop_ff + LW'(1);
                           if (loop_in >= LW'(ccount_ff)) begin
                              sect_in[SF_CODER_SIZES] = 1'b1;
                              phase_in = PH_UNPACK_PROP;
                           end
                        end
                     end
                     default: rej_in = 1'b1;
                  endcase
               end
            end

            // start a skip, or go straight on when its length is zero
            if (skip_req) begin
               if (skip_n == 64'd0) begin
                  do_enter = 1'b1; ecode = skip_r;
               end else begin
                  skip_in = skip_n; ret_in = skip_r; phase_in = PH_SKIPPING;
               end
            end

            // return action of a finished skip
            if (do_enter) begin
               case (ecode)
                  ACT_AFTER_ID: begin
                     if (flags_in[4]) phase_in = PH_CODER_IN;
                     else begin
                        inputs_in = 31'd1; do_add = 1'b1;
                     end
                  end
                  ACT_CODER_NEXT: do_next = 1'b1;
                  default: phase_in = ecode;
               endcase
            end

            // count the coder's input streams
            if (do_add) begin
               if (stotal_in >= SCW'(MAX_STREAMS) ||
                   32'(inputs_in) > 32'(MAX_STREAMS) - 32'(stotal_in)) begin
                  rej_in = 1'b1;
               end else begin
                  stotal_in = stotal_in + inputs_in[SCW-1:0];
                  if (flags_in[5]) phase_in = PH_PROPS_SIZE;
                  else do_next = 1'b1;
               end
            end

            // next coder, or check the stream balance
            if (do_next) begin
               loop_in = loop_in + LW'(1);
               if (loop_in < LW'(ccount_in)) begin
                  phase_in = PH_CODER_MAIN;
               end else begin
                  bonds = ccount_in - CCW'(1);
                  if (8'(stotal_in) < 8'(bonds) ||
                      8'(stotal_in) - 8'(bonds) != 8'(pcount_in)) begin
                     rej_in = 1'b1;
                  end else begin
                     cused_in = '0; sused_in = '0; loop_in = '0;
                     if (bonds != '0) phase_in = PH_BOND_IN;
                     else do_pis = 1'b1;
                  end
               end
            end

            // pack stream indices only when more than one stream
            if (do_pis) begin
               if (pcount_in != SCW'(1)) begin
                  loop_in = '0; phase_in = PH_PACK_INDEX;
               end else begin
                  do_ff = 1'b1;
               end
            end

            // close the folder: first coder with no bond is the main one
            if (do_ff) begin
               for (int i = 0; i < MAX_CODERS; i++) begin
                  if (!found && CCW'(i) < ccount_in && !cused_in[i]) begin
                     found   = 1'b1;
                     main_in = CIW'(i);
                  end
               end
               if (!found) begin
                  rej_in = 1'b1;
               end else begin
                  flen_in  = 16'(offset_ff) + 16'd1 - fstart_in;
                  sect_in[SF_FOLDER] = 1'b1;
                  phase_in = PH_UNPACK_PROP;
               end
            end
         end
      end

      // byte offset saturates just past the record limit
      if (take && offset_ff <= OW'(RECORD_BYTES_MAX))
         offset_in = offset_ff + OW'(1);
   end

   // snapshot for the emitter at the last byte
   always_comb begin
      summary               = '0;
      summary.ok            = !rej_in && (phase_in == PH_DONE);
      summary.pack_position = ppos_in;
      summary.pack_num      = 6'(pcount_in);
      summary.coder_num     = 4'(ccount_in);
      summary.main_coder    = 3'(main_in);
      summary.folder_start  = fstart_in;
      summary.folder_length = flen_in;
      summary.crc_present   = sect_in[SF_CRC];
      summary.folder_crc    = sect_in[SF_CRC] ? crc_in : 32'd0;
   end

   // parse state, cleared at reset and after each record
   always_ff @(posedge clock) begin
      if (reset || start) begin
         phase_ff <= PH_FIRST; acc_ff <= '0; lead_ff <= '0; cnt_ff <= '0;
         need_ff <= '0; active_ff <= 1'b0; skip_ff <= '0; ret_ff <= PH_FIRST;
         offset_ff <= '0; ppos_ff <= '0; ptotal_ff <= '0; loop_ff <= '0;
         flags_ff <= '0; stotal_ff <= '0; inputs_ff <= '0; pcount_ff <= '0;
         ccount_ff <= '0; main_ff <= '0; cused_ff <= '0; sused_ff <= '0;
         sect_ff <= '0; crc_ff <= '0; rej_ff <= 1'b0; fstart_ff <= '0; flen_ff <= '0;
      end else begin
         phase_ff <= phase_in; acc_ff <= acc_in; lead_ff <= lead_in; cnt_ff <= cnt_in;
         need_ff <= need_in; active_ff <= active_in; skip_ff <= skip_in; ret_ff <= ret_in;
         offset_ff <= offset_in; ppos_ff <= ppos_in; ptotal_ff <= ptotal_in;
         loop_ff <= loop_in; flags_ff <= flags_in; stotal_ff <= stotal_in;
         inputs_ff <= inputs_in; pcount_ff <= pcount_in; ccount_ff <= ccount_in;
         main_ff <= main_in; cused_ff <= cused_in; sused_ff <= sused_in;
         sect_ff <= sect_in; crc_ff <= crc_in; rej_ff <= rej_in;
         fstart_ff <= fstart_in; flen_ff <= flen_in;
      end
   end

   // size tables
   always_ff @(posedge clock) begin
      if (ps_we) pack_sizes_ff[ps_idx] <= wr_data;
      if (cs_we) coder_sizes_ff[cs_idx] <= wr_data;
   end

endmodule

@@ rtl/szs_emitter.sv @@
// ----------------------------------------------------------------------------
// szs_emitter
// Walks the results of a finished record into the output register.
// ----------------------------------------------------------------------------
module szs_emitter import szs_pkg::*; #(
   parameter int MAX_STREAMS = 8,
   parameter int MAX_CODERS  = 4,
   localparam int SIW = (MAX_STREAMS > 1) ? $clog2(MAX_STREAMS) : 1,
   localparam int CIW = (MAX_CODERS > 1) ? $clog2(MAX_CODERS) : 1
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  summary_type    summary,
   output logic           busy,
   output logic [SIW-1:0] pack_rd_idx,
   input  logic [63:0]    pack_rd_data,
   output logic [CIW-1:0] coder_rd_idx,
   input  logic [63:0]    coder_rd_data,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output logic [1:0]     rsp_kind,
   output logic [2:0]     rsp_entry_index,
   output logic [63:0]    rsp_value,
   output logic           rsp_status,
   output logic [3:0]     rsp_pack_count,
   output logic [2:0]     rsp_coder_count,
   output logic [1:0]     rsp_main_coder,
   output logic [15:0]    rsp_folder_start,
   output logic [15:0]    rsp_folder_length,
   output logic [31:0]    rsp_folder_crc,
   output logic           rsp_crc_present,
   output logic           rsp_last_result
);

   localparam logic [2:0] E_IDLE  = 3'd0;
   localparam logic [2:0] E_POS   = 3'd1;
   localparam logic [2:0] E_PACK  = 3'd2;
   localparam logic [2:0] E_CODER = 3'd3;
   localparam logic [2:0] E_SUM   = 3'd4;
   localparam logic [2:0] E_REJ   = 3'd5;

   logic [2:0]  state_ff, state_in;
   logic [5:0]  idx_ff, idx_in;
   summary_type sum_ff;
   logic        valid_ff, valid_in;
   logic        load, out_free;
   logic [1:0]  kind_in;
   logic [63:0] value_in;
   logic        status_in, last_in;

   assign busy         = (state_ff != E_IDLE);
   assign out_free     = !valid_ff || rsp_ready;
   assign load         = busy && out_free;
   assign pack_rd_idx  = idx_ff[SIW-1:0];
   assign coder_rd_idx = (state_ff == E_SUM) ? sum_ff.main_coder[CIW-1:0]
                                             : idx_ff[CIW-1:0];
   assign rsp_valid    = valid_ff;

   // result sequence
   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      kind_in   = KIND_SUMMARY;
      value_in  = 64'd0;
      status_in = 1'b0;
      last_in   = 1'b0;
      valid_in  = valid_ff && !rsp_ready;
      if (start) begin
         state_in = summary.ok ? E_POS : E_REJ;
         idx_in   = 6'd0;
      end else if (load) begin
         valid_in = 1'b1;
         case (state_ff)
            E_POS: begin
               kind_in  = KIND_PACK_POS;
               value_in = sum_ff.pack_position;
               state_in = E_PACK;
            end
            E_PACK: begin
               kind_in  = KIND_PACK_SIZE;
               value_in = pack_rd_data;
               idx_in   = idx_ff + 6'd1;
               if (idx_in >= sum_ff.pack_num) begin
                  idx_in = 6'd0; state_in = E_CODER;
               end
            end
            E_CODER: begin
               kind_in  = KIND_CODER_SIZE;
               value_in = coder_rd_data;
               idx_in   = idx_ff + 6'd1;
               if (idx_in >= 6'(sum_ff.coder_num)) begin
                  idx_in = 6'd0; state_in = E_SUM;
               end
            end
            E_SUM: begin
               kind_in  = KIND_SUMMARY;
               value_in = coder_rd_data;
               last_in  = 1'b1;
               state_in = E_IDLE;
            end
            E_REJ: begin
               status_in = 1'b1;
               last_in   = 1'b1;
               state_in  = E_IDLE;
            end
            default: state_in = E_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= E_IDLE;
         idx_ff   <= 6'd0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   // record snapshot and output register
   always_ff @(posedge clock) begin
      if (start) sum_ff <= summary;
      if (load) begin
         rsp_kind          <= kind_in;
         rsp_entry_index   <= (state_ff == E_PACK || state_ff == E_CODER) ? idx_ff[2:0]
                                                                          : 3'd0;
         rsp_value         <= value_in;
         rsp_status        <= status_in;
         rsp_last_result   <= last_in;
         rsp_pack_count    <= status_in ? 4'd0  : sum_ff.pack_num[3:0];
         rsp_coder_count   <= status_in ? 3'd0  : sum_ff.coder_num[2:0];
         rsp_main_coder    <= status_in ? 2'd0  : sum_ff.main_coder[1:0];
         rsp_folder_start  <= status_in ? 16'd0 : sum_ff.folder_start;
         rsp_folder_length <= status_in ? 16'd0 : sum_ff.folder_length;
         rsp_folder_crc    <= status_in ? 32'd0 : sum_ff.folder_crc;
         rsp_crc_present   <= status_in ? 1'b0  : sum_ff.crc_present;
      end
   end

endmodule

@@ rtl/sevenz_streams_info_parser.sv @@
// ----------------------------------------------------------------------------
// sevenz_streams_info_parser
// 7z encoded-header streams-info parser: queue, byte parser, result emitter.
// ----------------------------------------------------------------------------
// Record bytes enter a two-entry queue and the parser takes one byte per
// cycle while the emitter is idle, decoding variable-length numbers and
// the PackInfo and UnpackInfo sections as it goes. On the byte marked
// last, the emitter sends the pack position, one pack size per stream,
// one unpack size per coder and a summary (or a single reject result),
// one result per cycle while the output is taken; the parser holds off
// further bytes during that walk. The walk is set by the single read
// port of each size table.
module sevenz_streams_info_parser import szs_pkg::*; #(
   parameter int MAX_STREAMS      = 8,
   parameter int MAX_CODERS       = 4,
   parameter int RECORD_BYTES_MAX = 65536
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [2:0]  rsp_entry_index,
   output logic [63:0] rsp_value,
   output logic        rsp_status,
   output logic [3:0]  rsp_pack_count,
   output logic [2:0]  rsp_coder_count,
   output logic [1:0]  rsp_main_coder,
   output logic [15:0] rsp_folder_start,
   output logic [15:0] rsp_folder_length,
   output logic [31:0] rsp_folder_crc,
   output logic        rsp_crc_present,
   output logic        rsp_last_result
);

   localparam int SIW = (MAX_STREAMS > 1) ? $clog2(MAX_STREAMS) : 1;
   localparam int CIW = (MAX_CODERS > 1) ? $clog2(MAX_CODERS) : 1;

   logic           q_valid, q_ready, q_last;
   logic [7:0]     q_byte;
   logic           emit_busy, start;
   summary_type    summary;
   logic [SIW-1:0] pack_rd_idx;
   logic [CIW-1:0] coder_rd_idx;
   logic [63:0]    pack_rd_data, coder_rd_data;

   // front: byte queue
   szs_byte_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_byte   (req_data_byte),
      .in_last   (req_last_byte),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_byte  (q_byte),
      .out_last  (q_last)
   );

   // back: parser
   szs_parser #(
      .MAX_STREAMS      (MAX_STREAMS),
      .MAX_CODERS       (MAX_CODERS),
      .RECORD_BYTES_MAX (RECORD_BYTES_MAX)
   ) u_parser (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (q_valid),
      .in_ready      (q_ready),
      .in_byte       (q_byte),
      .in_last       (q_last),
      .emit_busy     (emit_busy),
      .start         (start),
      .summary       (summary),
      .pack_rd_idx   (pack_rd_idx),
      .pack_rd_data  (pack_rd_data),
      .coder_rd_idx  (coder_rd_idx),
      .coder_rd_data (coder_rd_data)
   );

   // result emitter
   szs_emitter #(
      .MAX_STREAMS (MAX_STREAMS),
      .MAX_CODERS  (MAX_CODERS)
   ) u_emitter (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .summary           (summary),
      .busy              (emit_busy),
      .pack_rd_idx       (pack_rd_idx),
      .pack_rd_data      (pack_rd_data),
      .coder_rd_idx      (coder_rd_idx),
      .coder_rd_data     (coder_rd_data),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_kind          (rsp_kind),
      .rsp_entry_index   (rsp_entry_index),
      .rsp_value         (rsp_value),
      .rsp_status        (rsp_status),
      .rsp_pack_count    (rsp_pack_count),
      .rsp_coder_count   (rsp_coder_count),
      .rsp_main_coder    (rsp_main_coder),
      .rsp_folder_start  (rsp_folder_start),
      .rsp_folder_length (rsp_folder_length),
      .rsp_folder_crc    (rsp_folder_crc),
      .rsp_crc_present   (rsp_crc_present),
      .rsp_last_result   (rsp_last_result)
   );

   // parser never takes a byte during a result walk
   a_no_byte_while_emitting: assert property (@(posedge clock) disable iff (reset)
      emit_busy |-> !(q_valid && q_ready))
      else $error("parser took a byte while results were pending");

   // a record end always starts a result walk
   a_start_walk: assert property (@(posedge clock) disable iff (reset)
      start |=> emit_busy)
      else $error("record end did not start the emitter");

   // a reject is a single final result
   a_reject_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status) |-> rsp_last_result)
      else $error("reject result not marked final");

   // in an accepted record only the summary is final
   a_summary_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_status) |-> ((rsp_kind == KIND_SUMMARY) == rsp_last_result))
      else $error("summary and final marker disagree");

endmodule
